// ===== rtl/rmth_pkg.sv =====
`timescale 1ns / 1ps

package rmth_pkg;

	// width of the sample_count result field
	localparam int unsigned COUNT_BITS = 11;

	// operation broadcast to every cell of one half
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_PUSH_HEAD,
		OP_REPLACE_TOP
	} op_t;

	// per-cell status handed to both neighbors
	typedef struct packed {
		logic valid;   // cell holds a sample
		logic ahead;   // stored value sorts strictly before the key
	} flags_t;

endpackage

// ===== rtl/rmth_cell.sv =====
`timescale 1ns / 1ps

module rmth_cell #(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmth_pkg::op_t                op,
	input  logic signed [VALUE_BITS-1:0] key,
	input  rmth_pkg::flags_t             prev_flags,
	input  logic signed [VALUE_BITS-1:0] prev_val,
	input  rmth_pkg::flags_t             next_flags,
	input  logic signed [VALUE_BITS-1:0] next_val,
	output rmth_pkg::flags_t             flags,
	output logic signed [VALUE_BITS-1:0] val
);

	logic signed [VALUE_BITS-1:0] val_q;
	logic                         valid_q;
	logic signed [VALUE_BITS-1:0] val_d;
	logic                         valid_d;
	logic                         ahead;

	// a push at the head treats every cell as sorting after the key
	assign ahead = valid_q && (val_q < key) &&
		(op == rmth_pkg::OP_INSERT || op == rmth_pkg::OP_REPLACE_TOP);

	assign flags.valid = valid_q;
	assign flags.ahead = ahead;
	assign val         = val_q;

	always_comb begin
		val_d   = val_q;
		valid_d = valid_q;
		unique case (op) inside
			rmth_pkg::OP_HOLD: begin
			end
			rmth_pkg::OP_INSERT, rmth_pkg::OP_PUSH_HEAD: begin
				// open a slot: cells past the key take their left neighbor
				if (!ahead) begin
					val_d   = prev_flags.ahead ? key : prev_val;
					valid_d = prev_flags.valid;
				end
			end
			rmth_pkg::OP_REPLACE_TOP: begin
				// drop the head: cells before the key take their right neighbor, the last of them takes the key
				if (next_flags.ahead) begin
					val_d = next_val;
				end else if (ahead) begin
					val_d = key;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ===== rtl/rmth_chain.sv =====
`timescale 1ns / 1ps

module rmth_chain #(
	parameter int unsigned DEPTH      = 512,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmth_pkg::op_t                op,
	input  logic signed [VALUE_BITS-1:0] key,
	output rmth_pkg::flags_t             head_flags,
	output logic signed [VALUE_BITS-1:0] head_val
);

	rmth_pkg::flags_t             cell_flags [DEPTH];
	logic signed [VALUE_BITS-1:0] cell_val   [DEPTH];

	// ascending order: the smallest value sits in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rmth_pkg::flags_t             prev_flags;
		logic signed [VALUE_BITS-1:0] prev_val;
		rmth_pkg::flags_t             next_flags;
		logic signed [VALUE_BITS-1:0] next_val;

		if (i == 0) begin : g_first
			assign prev_flags = '{valid: 1'b1, ahead: 1'b1};
			assign prev_val   = key;
		end else begin : g_mid
			assign prev_flags = cell_flags[i-1];
			assign prev_val   = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_flags = '{valid: 1'b0, ahead: 1'b0};
			assign next_val   = key;
		end else begin : g_inner
			assign next_flags = cell_flags[i+1];
			assign next_val   = cell_val[i+1];
		end

		rmth_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.key       (key),
			.prev_flags(prev_flags),
			.prev_val  (prev_val),
			.next_flags(next_flags),
			.next_val  (next_val),
			.flags     (cell_flags[i]),
			.val       (cell_val[i])
		);
	end

	assign head_flags = cell_flags[0];
	assign head_val   = cell_val[0];

endmodule

// ===== rtl/running_median_two_heaps_top.sv =====
// A result is registered from the half heads while the pending flag is set; that flag
// is set when a sample beat is taken. No new sample is taken while one is pending or an
// unread result holds the output; each half updates all its cells in the accept cycle.
// Reset clears the sample count, the pending and result valid flags and every
// cell's valid bit; stored sample values and result fields are left as they are.
`timescale 1ns / 1ps

module running_median_two_heaps_top #(
	parameter int unsigned CAPACITY   = 1024,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS:0]   median_doubled,
	output logic [rmth_pkg::COUNT_BITS-1:0] sample_count,
	output logic                         dropped
);

	localparam int unsigned LOW_DEPTH = CAPACITY / 2;
	localparam int unsigned UP_DEPTH  = (CAPACITY + 1) / 2;
	localparam int unsigned CW        = $clog2(CAPACITY + 1);

	logic [CW-1:0]                count_q;
	logic                         pend_q;
	logic                         drop_pend_q;
	logic                         out_valid_q;
	logic signed [VALUE_BITS:0]   median_q;
	logic [rmth_pkg::COUNT_BITS-1:0] count_out_q;
	logic                         dropped_q;

	logic                         accept;
	logic                         full;
	logic                         even;
	rmth_pkg::op_t                low_op;
	rmth_pkg::op_t                up_op;
	logic signed [VALUE_BITS-1:0] low_key;
	logic signed [VALUE_BITS-1:0] up_key;
	rmth_pkg::flags_t             low_head_flags;
	rmth_pkg::flags_t             up_head_flags;
	logic signed [VALUE_BITS-1:0] low_head;
	logic signed [VALUE_BITS-1:0] up_head;
	logic signed [VALUE_BITS-1:0] low_top;
	logic signed [VALUE_BITS:0]   median_d;
	logic [CW+rmth_pkg::COUNT_BITS-1:0] count_ext;

	assign in_ready = !pend_q && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign full     = count_q >= CW'(CAPACITY);
	assign even     = !count_q[0];

	// the lower half is kept bit-inverted, which turns its max order into min order
	assign low_top = ~low_head;

	always_comb begin
		low_op  = rmth_pkg::OP_HOLD;
		up_op   = rmth_pkg::OP_HOLD;
		low_key = ~sample;
		up_key  = sample;
		if (accept && !full) begin
			if (even) begin
				if (count_q != '0 && sample < low_top) begin
					// sample belongs low: lower top moves up
					low_op = rmth_pkg::OP_REPLACE_TOP;
					up_op  = rmth_pkg::OP_PUSH_HEAD;
					up_key = low_top;
				end else begin
					up_op = rmth_pkg::OP_INSERT;
				end
			end else begin
				if (sample > up_head) begin
					// sample belongs high: upper top moves down
					up_op   = rmth_pkg::OP_REPLACE_TOP;
					low_op  = rmth_pkg::OP_PUSH_HEAD;
					low_key = ~up_head;
				end else begin
					low_op = rmth_pkg::OP_INSERT;
				end
			end
		end
	end

	rmth_chain #(
		.DEPTH     (LOW_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_low (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (low_op),
		.key       (low_key),
		.head_flags(low_head_flags),
		.head_val  (low_head)
	);

	rmth_chain #(
		.DEPTH     (UP_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (up_op),
		.key       (up_key),
		.head_flags(up_head_flags),
		.head_val  (up_head)
	);

	always_comb begin
		median_d = '0;
		if (!even) begin
			median_d = {up_head, 1'b0};
		end else if (count_q != '0) begin
			median_d = {low_top[VALUE_BITS-1], low_top} + {up_head[VALUE_BITS-1], up_head};
		end
	end

	assign count_ext = (CW + rmth_pkg::COUNT_BITS)'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			drop_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_q      <= 1'b1;
				drop_pend_q <= full;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (pend_q) begin
				pend_q <= 1'b0;
			end
			// load the result beat once the halves have settled
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			median_q    <= median_d;
			count_out_q <= count_ext[rmth_pkg::COUNT_BITS-1:0];
			dropped_q   <= drop_pend_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign median_doubled = median_q;
	assign sample_count   = count_out_q;
	assign dropped        = dropped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("sample count above capacity");

	a_pend_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> out_valid_q && !pend_q)
		else $error("pending result not loaded into the output register");

	a_up_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		up_head_flags.valid == (count_q != '0))
		else $error("upper half head valid disagrees with count");

	a_low_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		low_head_flags.valid == (count_q > CW'(1)))
		else $error("lower half head valid disagrees with count");

	a_halves_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CW'(1)) |-> (low_top <= up_head))
		else $error("lower half top above upper half top");

endmodule
